[rtl/core/kss_pkg.sv]
package kss_pkg;

   localparam int MaxItems  = 1024;
   localparam int DataBits  = 32;
   localparam int IndexBits = $clog2(MaxItems);
   localparam int CountBits = IndexBits + 1;
   localparam int RankBits  = 11;
   localparam int SizeBits  = 11;

   localparam logic [1:0] StatusOk   = 2'd0;
   localparam logic [1:0] StatusRank = 2'd1;
   localparam logic [1:0] StatusDrop = 2'd2;

   typedef struct packed {
      logic [DataBits-1:0] item_value;
      logic                last;
   } kss_req_type;

   typedef struct packed {
      logic [DataBits-1:0] selected_value;
      logic [SizeBits-1:0] set_size;
      logic [1:0]          status;
   } kss_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [IndexBits-1:0] last_idx;
      logic [IndexBits-1:0] target;
   } kss_cmd_type;

   typedef struct packed {
      logic                done;
      logic [DataBits-1:0] value;
   } kss_done_type;

   typedef struct packed {
      logic                 wr_en;
      logic [IndexBits-1:0] wr_addr;
      logic [DataBits-1:0]  wr_data;
      logic [IndexBits-1:0] rd_addr;
   } kss_mem_req_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_START,
      ENG_PIVOT,
      ENG_LREAD,
      ENG_LSCAN,
      ENG_RSCAN,
      ENG_SWAP,
      ENG_DONE
   } kss_eng_state_type;

   typedef enum logic [1:0] {
      TOP_LOAD,
      TOP_SELECT,
      TOP_EMIT
   } kss_top_state_type;

endpackage

[rtl/core/kss_ram.sv]
module kss_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/kss_engine.sv]
module kss_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  kss_pkg::kss_cmd_type           cmd,
   input  logic [kss_pkg::DataBits-1:0]   rd_data,
   output kss_pkg::kss_mem_req_type       mem_req,
   output kss_pkg::kss_done_type          result
);

   kss_pkg::kss_eng_state_type state_ff, state_in;
   logic [kss_pkg::IndexBits-1:0] low_ff, low_in;
   logic [kss_pkg::IndexBits-1:0] high_ff, high_in;
   logic [kss_pkg::IndexBits-1:0] left_ff, left_in;
   logic [kss_pkg::IndexBits-1:0] right_ff, right_in;
   logic [kss_pkg::IndexBits-1:0] target_ff, target_in;
   logic [kss_pkg::DataBits-1:0]  pivot_ff, pivot_in;
   logic [kss_pkg::DataBits-1:0]  lval_ff, lval_in;
   logic [kss_pkg::IndexBits:0]   mid_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kss_pkg::ENG_IDLE;
      end else begin
         state_ff <= state_in;
      end
      low_ff    <= low_in;
      high_ff   <= high_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
      target_ff <= target_in;
      pivot_ff  <= pivot_in;
      lval_ff   <= lval_in;
   end

   assign mid_sum = {1'b0, low_ff} + {1'b0, high_ff};

   always_comb begin
      state_in        = state_ff;
      low_in          = low_ff;
      high_in         = high_ff;
      left_in         = left_ff;
      right_in        = right_ff;
      target_in       = target_ff;
      pivot_in        = pivot_ff;
      lval_in         = lval_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = left_ff;
      mem_req.wr_data = rd_data;
      mem_req.rd_addr = left_ff;
      result.done     = 1'b0;
      result.value    = rd_data;

      unique case (state_ff)
         kss_pkg::ENG_IDLE: begin
            if (cmd.start) begin
               low_in    = '0;
               high_in   = cmd.last_idx;
               target_in = cmd.target;
               state_in  = kss_pkg::ENG_START;
            end
         end
         kss_pkg::ENG_START: begin
            // fetch the middle element, or the ranked one once the range is a single entry
            if (low_ff < high_ff) begin
               mem_req.rd_addr = mid_sum[kss_pkg::IndexBits:1];
               state_in        = kss_pkg::ENG_PIVOT;
            end else begin
               mem_req.rd_addr = target_ff;
               state_in        = kss_pkg::ENG_DONE;
            end
         end
         kss_pkg::ENG_PIVOT: begin
            pivot_in        = rd_data;
            left_in         = low_ff;
            right_in        = high_ff;
            mem_req.rd_addr = low_ff;
            state_in        = kss_pkg::ENG_LSCAN;
         end
         kss_pkg::ENG_LREAD: begin
            mem_req.rd_addr = left_ff;
            state_in        = kss_pkg::ENG_LSCAN;
         end
         kss_pkg::ENG_LSCAN: begin
            if ((left_ff < high_ff) && (rd_data < pivot_ff)) begin
               left_in         = left_ff + 1'b1;
               mem_req.rd_addr = left_ff + 1'b1;
            end else begin
               lval_in         = rd_data;
               mem_req.rd_addr = right_ff;
               state_in        = kss_pkg::ENG_RSCAN;
            end
         end
         kss_pkg::ENG_RSCAN: begin
            if ((right_ff > low_ff) && (rd_data > pivot_ff)) begin
               right_in        = right_ff - 1'b1;
               mem_req.rd_addr = right_ff - 1'b1;
            end else if (left_ff >= right_ff) begin
               // split at right: keep the side that holds the rank
               if (target_ff <= right_ff) begin
                  high_in = right_ff;
               end else begin
                  low_in = right_ff + 1'b1;
               end
               state_in = kss_pkg::ENG_START;
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = left_ff;
               mem_req.wr_data = rd_data;
               state_in        = kss_pkg::ENG_SWAP;
            end
         end
         kss_pkg::ENG_SWAP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = right_ff;
            mem_req.wr_data = lval_ff;
            left_in         = left_ff + 1'b1;
            right_in        = right_ff - 1'b1;
            state_in        = kss_pkg::ENG_LREAD;
         end
         kss_pkg::ENG_DONE: begin
            result.done = 1'b1;
            state_in    = kss_pkg::ENG_IDLE;
         end
         default: begin
            state_in = kss_pkg::ENG_IDLE;
         end
      endcase
   end

endmodule

[rtl/core/kth_smallest_select.sv]
// k-th smallest value selector.
// req_ channel: one transaction carries one value and a last flag. Values
// are stored in order into a 1024-entry element memory, one per cycle, and
// req_ready stays high throughout loading. Values arriving once the memory
// is full are dropped and the set is flagged.
// The transaction marked last closes the set. If values were dropped, or
// the rank in csr_ (1-based, reset value 1) is zero or beyond the set
// size, the flagged result is formed at once. Otherwise quickselect runs
// over the memory: Hoare partition rounds around the middle element, one
// memory access per cycle through a single registered read port; run time
// grows up to quadratically with the set size in the worst case. req_ready
// is low from the last transaction until its result is placed in the
// output register.
// rsp_ channel: one transaction per set, held in an output register; a
// stalled receiver holds it there while the next set keeps loading.
// Reset (synchronous) clears the set count and flags and returns the rank
// register to 1; memory contents are left as they are and need no clearing.
module kth_smallest_select (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  kss_pkg::kss_req_type          req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output kss_pkg::kss_rsp_type          rsp_payload,
   input  logic                          csr_wr_en,
   input  logic [kss_pkg::RankBits-1:0]  csr_wr_data
);

   kss_pkg::kss_top_state_type state_ff, state_in;
   logic [kss_pkg::CountBits-1:0] count_ff, count_in;
   logic                          ovf_ff, ovf_in;
   logic [kss_pkg::RankBits-1:0]  rank_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   kss_pkg::kss_rsp_type          rsp_payload_ff, rsp_payload_in;
   logic [kss_pkg::DataBits-1:0]  res_value_ff, res_value_in;
   logic [1:0]                    res_status_ff, res_status_in;

   logic [kss_pkg::CountBits-1:0] new_count;
   logic                          full;
   logic [kss_pkg::IndexBits-1:0] rank_m1;

   kss_pkg::kss_cmd_type          cmd;
   kss_pkg::kss_done_type         eng_result;
   kss_pkg::kss_mem_req_type      eng_mem_req;
   logic                          ram_wr_en;
   logic [kss_pkg::IndexBits-1:0] ram_wr_addr;
   logic [kss_pkg::DataBits-1:0]  ram_wr_data;
   logic [kss_pkg::DataBits-1:0]  ram_rd_data;

   kss_ram #(
      .DEPTH (kss_pkg::MaxItems),
      .WIDTH (kss_pkg::DataBits)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (eng_mem_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   kss_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_data (ram_rd_data),
      .mem_req (eng_mem_req),
      .result  (eng_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kss_pkg::TOP_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rank_ff      <= kss_pkg::RankBits'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            rank_ff <= csr_wr_data;
         end
      end
      rsp_payload_ff <= rsp_payload_in;
      res_value_ff   <= res_value_in;
      res_status_ff  <= res_status_in;
   end

   assign full      = (count_ff == kss_pkg::CountBits'(kss_pkg::MaxItems));
   assign new_count = full ? count_ff : count_ff + 1'b1;
   assign rank_m1   = kss_pkg::IndexBits'(rank_ff - 1'b1);

   assign req_ready   = (state_ff == kss_pkg::TOP_LOAD);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      ovf_in         = ovf_ff;
      // drop the output transaction once taken
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      res_value_in   = res_value_ff;
      res_status_in  = res_status_ff;
      cmd.start      = 1'b0;
      cmd.last_idx   = kss_pkg::IndexBits'(new_count - 1'b1);
      cmd.target     = rank_m1;
      ram_wr_en      = eng_mem_req.wr_en;
      ram_wr_addr    = eng_mem_req.wr_addr;
      ram_wr_data    = eng_mem_req.wr_data;

      unique case (state_ff)
         kss_pkg::TOP_LOAD: begin
            ram_wr_en   = 1'b0;
            ram_wr_addr = count_ff[kss_pkg::IndexBits-1:0];
            ram_wr_data = req_payload.item_value;
            if (req_valid) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  ram_wr_en = 1'b1;
                  count_in  = new_count;
               end
               if (req_payload.last) begin
                  res_value_in = '0;
                  state_in     = kss_pkg::TOP_EMIT;
                  if (ovf_ff || full) begin
                     res_status_in = kss_pkg::StatusDrop;
                  end else if ((rank_ff == '0) ||
                               (rank_ff > kss_pkg::RankBits'(new_count))) begin
                     res_status_in = kss_pkg::StatusRank;
                  end else begin
                     // advance to selection over entries 0 .. new_count-1
                     res_status_in = kss_pkg::StatusOk;
                     cmd.start     = 1'b1;
                     state_in      = kss_pkg::TOP_SELECT;
                  end
               end
            end
         end
         kss_pkg::TOP_SELECT: begin
            if (eng_result.done) begin
               res_value_in = eng_result.value;
               state_in     = kss_pkg::TOP_EMIT;
            end
         end
         kss_pkg::TOP_EMIT: begin
            // hold until the output register is free, then start a new set
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                  = 1'b1;
               rsp_payload_in.selected_value = res_value_ff;
               rsp_payload_in.set_size       = kss_pkg::SizeBits'(count_ff);
               rsp_payload_in.status         = res_status_ff;
               count_in                      = '0;
               ovf_in                        = 1'b0;
               state_in                      = kss_pkg::TOP_LOAD;
            end
         end
         default: begin
            state_in = kss_pkg::TOP_LOAD;
         end
      endcase
   end

endmodule
